// ----- hdl/takf_pkg.sv -----
// takf_pkg: types, constants and fixed-point helpers for the tilt angle kalman filter
// shared by the controller, the datapath and the top level; no dependencies
package takf_pkg;

	typedef struct packed {
		logic               axis;
		logic signed [15:0] accel_lateral;
		logic signed [15:0] accel_vertical;
		logic signed [31:0] gyro_rate;
	} sample_t;

	typedef struct packed {
		logic               axis_out;
		logic signed [31:0] angle_estimate;
		logic signed [31:0] bias_estimate;
	} result_t;

	// sign and magnitude value
	typedef struct packed {
		logic        neg;
		logic [63:0] mag;
	} smag_t;

	typedef struct packed {
		logic       load;
		logic       cinit;
		logic       cstep;
		logic [4:0] cstep_i;
		logic       mstep;
		logic [1:0] mpart;
		logic       mapply;
		logic [3:0] job;
		logic       pstep;
		logic       sstep;
		logic       dinit;
		logic       dstep;
		logic       dfin;
		logic       dsel;
		logic       estep;
		logic       wb;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	localparam int CFG_W = 48;
	localparam logic [1:0] CFG_SAMPLE_INTERVAL = 2'd0;
	localparam logic [1:0] CFG_ANGLE_NOISE     = 2'd1;
	localparam logic [1:0] CFG_BIAS_NOISE      = 2'd2;
	localparam logic [1:0] CFG_MEAS_NOISE      = 2'd3;

	localparam logic [31:0] RST_SAMPLE_INTERVAL = 32'd21474836;
	localparam logic [47:0] RST_ANGLE_NOISE     = 48'd28147;
	localparam logic [47:0] RST_BIAS_NOISE      = 48'd28147;
	localparam logic [47:0] RST_MEAS_NOISE      = 48'd28147497671;
	localparam logic [63:0] ONE_Q48             = 64'h0001_0000_0000_0000;

	localparam int CORDIC_STEPS = 28;
	localparam int MUL_PARTS    = 4;
	localparam int DIV_STEPS    = 112;
	localparam logic signed [33:0] PI_Q28 = 34'sd843314857;

	// multiply jobs, in issue order
	localparam logic [3:0] JOB_APRED  = 4'd0;
	localparam logic [3:0] JOB_P00A   = 4'd1;
	localparam logic [3:0] JOB_PCROSS = 4'd2;
	localparam logic [3:0] JOB_P00B   = 4'd3;
	localparam logic [3:0] JOB_APOST  = 4'd4;
	localparam logic [3:0] JOB_BPOST  = 4'd5;
	localparam logic [3:0] JOB_P10    = 4'd6;
	localparam logic [3:0] JOB_P11    = 4'd7;
	localparam logic [3:0] JOB_P00    = 4'd8;
	localparam logic [3:0] JOB_P01    = 4'd9;

	function automatic logic [31:0] cordic_atan(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:    r = 32'd210828714;
			5'd1:    r = 32'd124459457;
			5'd2:    r = 32'd65760959;
			5'd3:    r = 32'd33381290;
			5'd4:    r = 32'd16755422;
			5'd5:    r = 32'd8385879;
			5'd6:    r = 32'd4193963;
			5'd7:    r = 32'd2097109;
			5'd8:    r = 32'd1048571;
			5'd9:    r = 32'd524287;
			5'd10:   r = 32'd262144;
			default: r = 32'd1 << (5'd28 - i);
		endcase
		return r;
	endfunction

	function automatic smag_t sm_s(input logic [63:0] v);
		smag_t r;
		r.neg = v[63];
		r.mag = v[63] ? (~v + 64'd1) : v;
		return r;
	endfunction

	function automatic smag_t sm_u(input logic [63:0] v);
		smag_t r;
		r.neg = 1'b0;
		r.mag = v;
		return r;
	endfunction

	function automatic smag_t sm_neg(input smag_t a);
		smag_t r;
		r = a;
		if (a.mag != 64'd0) r.neg = ~a.neg;
		return r;
	endfunction

	function automatic smag_t sm_add(input smag_t a, input smag_t b);
		smag_t r;
		logic [64:0] sum;
		sum = {1'b0, a.mag} + {1'b0, b.mag};
		if (a.neg == b.neg) begin
			r.neg = a.neg;
			r.mag = sum[64] ? '1 : sum[63:0];
		end else if (a.mag >= b.mag) begin
			r.neg = a.neg;
			r.mag = a.mag - b.mag;
		end else begin
			r.neg = b.neg;
			r.mag = b.mag - a.mag;
		end
		if (r.mag == 64'd0) r.neg = 1'b0;
		return r;
	endfunction

	function automatic logic [31:0] sat32(input smag_t a);
		logic [31:0] r;
		if (!a.neg) r = (a.mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : a.mag[31:0];
		else r = (a.mag >= 64'h8000_0000) ? 32'h8000_0000 : (~a.mag[31:0] + 32'd1);
		return r;
	endfunction

	function automatic logic [63:0] sat64(input smag_t a);
		logic [63:0] r;
		if (!a.neg) r = a.mag[63] ? 64'h7FFF_FFFF_FFFF_FFFF : a.mag;
		else r = a.mag[63] ? 64'h8000_0000_0000_0000 : (~a.mag + 64'd1);
		return r;
	endfunction

	function automatic logic [63:0] satdiag(input smag_t a);
		return a.neg ? 64'd0 : a.mag;
	endfunction

endpackage

// ----- hdl/takf_ctrl.sv -----
// takf_ctrl: sequencer for one filter update (cordic, multiply jobs, divisions, writeback)
// depends on takf_pkg for command and status types and step counts
module takf_ctrl import takf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_ready,
	input  status_t stat,
	output cmd_t    cmd
);

	typedef enum logic [12:0] {
		S_IDLE  = 13'h0001,
		S_CINIT = 13'h0002,
		S_CSTEP = 13'h0004,
		S_MUL   = 13'h0008,
		S_MAPP  = 13'h0010,
		S_P00   = 13'h0020,
		S_SUM   = 13'h0040,
		S_DINIT = 13'h0080,
		S_DSTEP = 13'h0100,
		S_DFIN  = 13'h0200,
		S_ERR   = 13'h0400,
		S_OUT   = 13'h0800,
		S_SPARE = 13'h1000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;
	logic [6:0]  cnt_q, cnt_d;
	logic [3:0]  job_q, job_d;
	logic        dsel_q, dsel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			job_q   <= '0;
			dsel_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			job_q   <= job_d;
			dsel_q  <= dsel_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		job_d        = job_q;
		dsel_d       = dsel_q;
		cmd          = '0;
		cmd.job      = job_q;
		cmd.dsel     = dsel_q;
		cmd.mpart    = cnt_q[1:0];
		cmd.cstep_i  = cnt_q[4:0];
		sample_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CINIT;
				end
			end
			S_CINIT: begin
				cmd.cinit = 1'b1;
				cnt_d     = '0;
				state_d   = S_CSTEP;
			end
			S_CSTEP: begin
				cmd.cstep = 1'b1;
				if (cnt_q == 7'(CORDIC_STEPS - 1)) begin
					cnt_d   = '0;
					job_d   = JOB_APRED;
					state_d = S_MUL;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			S_MUL: begin
				cmd.mstep = 1'b1;
				if (cnt_q == 7'(MUL_PARTS - 1)) begin
					cnt_d   = '0;
					state_d = S_MAPP;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			S_MAPP: begin
				cmd.mapply = 1'b1;
				job_d      = job_q + 4'd1;
				if (job_q == JOB_P00B) state_d = S_P00;
				else if (job_q == JOB_P01) state_d = S_OUT;
				else state_d = S_MUL;
			end
			S_P00: begin
				cmd.pstep = 1'b1;
				state_d   = S_SUM;
			end
			S_SUM: begin
				cmd.sstep = 1'b1;
				dsel_d    = 1'b0;
				state_d   = S_DINIT;
			end
			S_DINIT: begin
				cmd.dinit = 1'b1;
				cnt_d     = '0;
				state_d   = S_DSTEP;
			end
			S_DSTEP: begin
				cmd.dstep = 1'b1;
				if (cnt_q == 7'(DIV_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = S_DFIN;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			S_DFIN: begin
				cmd.dfin = 1'b1;
				if (!dsel_q) begin
					dsel_d  = 1'b1;
					state_d = S_DINIT;
				end else begin
					state_d = S_ERR;
				end
			end
			S_ERR: begin
				cmd.estep = 1'b1;
				job_d     = JOB_APOST;
				state_d   = S_MUL;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.wb  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- hdl/takf_datapath.sv -----
// takf_datapath: per-axis filter state, config registers, cordic, sequenced multiplier,
// bit-serial divider and result register; driven by takf_ctrl, uses takf_pkg
module takf_datapath import takf_pkg::*; #(
	parameter int NUM_AXES = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output status_t          stat,
	input  sample_t          sample,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	output logic             result_valid,
	input  logic             result_ready,
	output result_t          result
);

	localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

	logic [31:0] t_q;
	logic [47:0] apn_q, bpn_q, rn_q;

	logic [31:0] ang_st_q [NUM_AXES];
	logic [31:0] bias_st_q [NUM_AXES];
	logic [63:0] p00_st_q [NUM_AXES];
	logic [63:0] p01_st_q [NUM_AXES];
	logic [63:0] p10_st_q [NUM_AXES];
	logic [63:0] p11_st_q [NUM_AXES];

	logic           axis_q;
	logic [AXW-1:0] k_q, k_in;
	logic [15:0]    ax_q, az_q;
	logic [31:0]    g_q, a_q, b_q, apred_q;
	logic [63:0]    p00_q, p01_q, p10_q, p11_q, s_q;
	smag_t          acc_q, k0_q, k1_q, e_q;

	logic signed [33:0] cx_q, cy_q, cz_q;
	logic               zero_q;

	logic [127:0] prod_q;
	logic [63:0]  num_q, rem_q, quo_q;
	logic         dzero_q, dovf_q;

	logic valid_q;
	result_t result_q;

	assign k_in = (NUM_AXES > 1) ? AXW'(sample.axis) : '0;

	// cordic step
	logic signed [17:0] yy, xx, xi, yi;
	logic signed [33:0] zi, dx, dy, ang;
	always_comb begin
		yy  = -{{2{ax_q[15]}}, ax_q};
		xx  = {{2{az_q[15]}}, az_q};
		xi  = xx;
		yi  = yy;
		zi  = '0;
		if (xx < 0) begin
			zi = (yy >= 0) ? PI_Q28 : -PI_Q28;
			xi = -xx;
			yi = -yy;
		end
		dx  = cy_q >>> cmd.cstep_i;
		dy  = cx_q >>> cmd.cstep_i;
		ang = $signed({2'b00, cordic_atan(cmd.cstep_i)});
	end

	// multiplier operands
	logic [32:0]  gmb;
	smag_t        op_a, op_b, m;
	logic [5:0]   sh;
	logic [31:0]  ha, hb;
	logic [63:0]  pp;
	logic [127:0] pp_ext, shifted;
	always_comb begin
		gmb = {g_q[31], g_q} - {b_q[31], b_q};
		op_a = sm_u({32'd0, t_q});
		op_b = sm_s({{31{gmb[32]}}, gmb});
		sh   = 6'd48;
		case (cmd.job)
			JOB_APRED:  sh = 6'd20;
			JOB_P00A: begin
				op_b = sm_s(p10_q);
				sh   = 6'd32;
			end
			JOB_PCROSS: begin
				op_b = sm_u(p11_q);
				sh   = 6'd32;
			end
			JOB_P00B: begin
				op_b = sm_s(p01_q);
				sh   = 6'd32;
			end
			JOB_APOST: begin
				op_a = k0_q;
				op_b = e_q;
			end
			JOB_BPOST: begin
				op_a = k1_q;
				op_b = e_q;
				sh   = 6'd60;
			end
			JOB_P10: begin
				op_a = k1_q;
				op_b = sm_u(p00_q);
			end
			JOB_P11: begin
				op_a = k1_q;
				op_b = sm_s(p01_q);
			end
			JOB_P00: begin
				op_a = k0_q;
				op_b = sm_u(p00_q);
			end
			JOB_P01: begin
				op_a = k0_q;
				op_b = sm_s(p01_q);
			end
			default: sh = 6'd48;
		endcase
		ha = cmd.mpart[1] ? op_a.mag[63:32] : op_a.mag[31:0];
		hb = cmd.mpart[0] ? op_b.mag[63:32] : op_b.mag[31:0];
		pp = ha * hb;
		case (cmd.mpart)
			2'd0:    pp_ext = {64'd0, pp};
			2'd3:    pp_ext = {pp, 64'd0};
			default: pp_ext = {32'd0, pp, 32'd0};
		endcase
		shifted = prod_q >> sh;
		m.mag   = (|shifted[127:64]) ? '1 : shifted[63:0];
		m.neg   = (op_a.neg ^ op_b.neg) && (m.mag != 64'd0);
	end

	// divider step
	logic [63:0] dnum;
	logic [63:0] r2;
	logic        rtop;
	logic [63:0] gain;
	smag_t       p10m;
	logic [33:0] meas;
	logic [34:0] ediff;
	logic [64:0] ssum;
	always_comb begin
		p10m  = sm_s(p10_q);
		dnum  = cmd.dsel ? p10m.mag : p00_q;
		rtop  = rem_q[63];
		r2    = {rem_q[62:0], num_q[63]};
		gain  = dzero_q ? 64'd0 : (dovf_q ? '1 : quo_q);
		meas  = zero_q ? '0 : cz_q;
		ediff = {meas[33], meas} - {{3{apred_q[31]}}, apred_q};
		ssum  = {1'b0, p00_q} + {17'd0, rn_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			axis_q <= sample.axis;
			k_q    <= k_in;
			ax_q   <= sample.accel_lateral;
			az_q   <= sample.accel_vertical;
			g_q    <= sample.gyro_rate;
			a_q    <= ang_st_q[k_in];
			b_q    <= bias_st_q[k_in];
			p00_q  <= p00_st_q[k_in];
			p01_q  <= p01_st_q[k_in];
			p10_q  <= p10_st_q[k_in];
			p11_q  <= p11_st_q[k_in];
		end
		if (cmd.cinit) begin
			zero_q <= (xx == 0) && (yy == 0);
			cx_q   <= 34'(xi) <<< 14;
			cy_q   <= 34'(yi) <<< 14;
			cz_q   <= zi;
		end
		if (cmd.cstep) begin
			if (cy_q > 0) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + ang;
			end else begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - ang;
			end
		end
		if (cmd.mstep) begin
			if (cmd.mpart == 2'd0) prod_q <= (128'd1 << (sh - 6'd1)) + pp_ext;
			else prod_q <= prod_q + pp_ext;
		end
		if (cmd.mapply) begin
			case (cmd.job)
				JOB_APRED:  apred_q <= sat32(sm_add(sm_s({{32{a_q[31]}}, a_q}), m));
				JOB_P00A:   acc_q <= sm_add(sm_u(p00_q), sm_neg(m));
				JOB_PCROSS: begin
					p01_q <= sat64(sm_add(sm_s(p01_q), sm_neg(m)));
					p10_q <= sat64(sm_add(sm_s(p10_q), sm_neg(m)));
				end
				JOB_P00B:   acc_q <= sm_add(acc_q, sm_neg(m));
				JOB_APOST:  apred_q <= sat32(sm_add(sm_s({{32{apred_q[31]}}, apred_q}), m));
				JOB_BPOST:  b_q <= sat32(sm_add(sm_s({{32{b_q[31]}}, b_q}), m));
				JOB_P10:    p10_q <= sat64(sm_add(sm_s(p10_q), sm_neg(m)));
				JOB_P11:    p11_q <= satdiag(sm_add(sm_u(p11_q), sm_neg(m)));
				JOB_P00:    p00_q <= satdiag(sm_add(sm_u(p00_q), sm_neg(m)));
				JOB_P01:    p01_q <= sat64(sm_add(sm_s(p01_q), sm_neg(m)));
				default:    acc_q <= acc_q;
			endcase
		end
		if (cmd.pstep) begin
			p00_q <= satdiag(sm_add(acc_q, sm_u({16'd0, apn_q})));
			p11_q <= satdiag(sm_add(sm_u(p11_q), sm_u({16'd0, bpn_q})));
		end
		if (cmd.sstep) s_q <= ssum[64] ? '1 : ssum[63:0];
		if (cmd.dinit) begin
			dzero_q <= (s_q == 64'd0);
			dovf_q  <= ({16'd0, dnum[63:16]} >= s_q);
			num_q   <= dnum;
			rem_q   <= '0;
			quo_q   <= '0;
		end
		if (cmd.dstep) begin
			num_q <= {num_q[62:0], 1'b0};
			if (rtop || (r2 >= s_q)) begin
				rem_q <= r2 - s_q;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= r2;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
		if (cmd.dfin) begin
			if (!cmd.dsel) k0_q <= sm_u(gain);
			else begin
				k1_q.mag <= gain;
				k1_q.neg <= p10m.neg && (gain != 64'd0);
			end
		end
		if (cmd.estep) e_q <= sm_s({{29{ediff[34]}}, ediff});
		if (cmd.wb) begin
			result_q.axis_out       <= axis_q;
			result_q.angle_estimate <= apred_q;
			result_q.bias_estimate  <= b_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q     <= RST_SAMPLE_INTERVAL;
			apn_q   <= RST_ANGLE_NOISE;
			bpn_q   <= RST_BIAS_NOISE;
			rn_q    <= RST_MEAS_NOISE;
			valid_q <= 1'b0;
			for (int i = 0; i < NUM_AXES; i++) begin
				ang_st_q[i]  <= '0;
				bias_st_q[i] <= '0;
				p00_st_q[i]  <= ONE_Q48;
				p01_st_q[i]  <= '0;
				p10_st_q[i]  <= '0;
				p11_st_q[i]  <= ONE_Q48;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SAMPLE_INTERVAL: t_q   <= cfg_wdata[31:0];
					CFG_ANGLE_NOISE:     apn_q <= cfg_wdata;
					CFG_BIAS_NOISE:      bpn_q <= cfg_wdata;
					CFG_MEAS_NOISE:      rn_q  <= cfg_wdata;
					default:             t_q   <= t_q;
				endcase
			end
			if (cmd.wb) begin
				valid_q         <= 1'b1;
				ang_st_q[k_q]  <= apred_q;
				bias_st_q[k_q] <= b_q;
				p00_st_q[k_q]  <= p00_q;
				p01_st_q[k_q]  <= p01_q;
				p10_st_q[k_q]  <= p10_q;
				p11_st_q[k_q]  <= p11_q;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_free = !valid_q || result_ready;
	assign result_valid  = valid_q;
	assign result        = result_q;

endmodule

// ----- hdl/tilt_angle_kalman_filter.sv -----
// tilt_angle_kalman_filter: top level, joins the sequencer and the datapath
// depends on takf_pkg, takf_ctrl and takf_datapath
//
// Each sample beat updates the two-state (angle, gyro bias) Kalman filter of its axis:
// the measured tilt comes from a 28-step vectoring cordic, the predict and correct
// steps run ten 64x64 products on one 32x32 multiplier, one partial product at a
// time, and two gains on a bit-serial divider, which accounts for most of the update
// time. The sequencer takes no new sample until the last update is written back.
// The result sits in an output register, so a new sample is taken while the last
// result still waits.
module tilt_angle_kalman_filter import takf_pkg::*; #(
	parameter int NUM_AXES = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_ready,
	input  sample_t          sample,
	output logic             result_valid,
	input  logic             result_ready,
	output result_t          result,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	cmd_t    cmd;
	status_t stat;

	takf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	takf_datapath #(
		.NUM_AXES (NUM_AXES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.sample       (sample),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
